// ===== rtl/ips_patch_encoder_core_assert.svh =====
// Assertion macros for the IPS patch encoder.
// Included by modules that check their own logic; expects clk and rst_n in scope.
`ifndef IPS_PATCH_ENCODER_CORE_ASSERT_SVH
`define IPS_PATCH_ENCODER_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define IPE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ips_patch_encoder_core: assertion failed");

// Condition that must never be seen out of reset.
`define IPE_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ips_patch_encoder_core: forbidden condition seen");

`endif

// ===== rtl/ipe_pkg.sv =====
// Shared types, constants and byte tables for the IPS patch encoder.
// No dependencies.
`default_nettype none

package ipe_pkg;

    localparam int POS_W     = 24;
    localparam int RUN_W     = 6;
    localparam int BUF_DEPTH = 48;
    localparam int ADDR_W    = 6;

    localparam logic [RUN_W-1:0] HDR_LAST_IDX = 6'd4;
    localparam logic [RUN_W-1:0] REC_LAST_IDX = 6'd4;
    localparam logic [RUN_W-1:0] EOF_LAST_IDX = 6'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_burst;
        logic       patch_done;
    } out_beat_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HDR  = 5'b00010,
        S_REC  = 5'b00100,
        S_DATA = 5'b01000,
        S_EOF  = 5'b10000
    } seq_state_t;

    // "PATCH"
    function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h50;
            3'd1:    b = 8'h41;
            3'd2:    b = 8'h54;
            3'd3:    b = 8'h43;
            default: b = 8'h48;
        endcase
        return b;
    endfunction

    // "EOF"
    function automatic logic [7:0] eof_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h45;
            2'd1:    b = 8'h4F;
            default: b = 8'h46;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ipe_in_if.sv =====
// Input channel: one base/modified byte pair per item.
// No dependencies.
`default_nettype none

interface ipe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_byte;
    logic [7:0] new_byte;
    logic       base_present;
    logic       end_of_file;

    modport source (output valid, base_byte, new_byte, base_present, end_of_file,
                    input ready);
    modport sink   (input valid, base_byte, new_byte, base_present, end_of_file,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/ipe_out_if.sv =====
// Output channel: one patch stream byte per item.
// No dependencies.
`default_nettype none

interface ipe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_burst;
    logic       patch_done;

    modport source (output valid, out_byte, last_of_burst, patch_done, input ready);
    modport sink   (input valid, out_byte, last_of_burst, patch_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/ipe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ipe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/ipe_out_reg.sv =====
// Output register stage for the patch byte stream.
// Depends on ipe_pkg and ipe_out_if.
`default_nettype none

module ipe_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ipe_pkg::out_beat_t beat,
    output logic                   can_push,
    ipe_out_if.source              tx
);

    import ipe_pkg::*;

    logic      valid_reg;
    out_beat_t beat_reg;

    // Loads when empty or when the held byte leaves this cycle.
    assign can_push = !valid_reg || tx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (tx.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            beat_reg <= beat;
        end
    end

    assign tx.valid         = valid_reg;
    assign tx.out_byte      = beat_reg.out_byte;
    assign tx.last_of_burst = beat_reg.last_of_burst;
    assign tx.patch_done    = beat_reg.patch_done;

endmodule

`default_nettype wire

// ===== rtl/ips_patch_encoder_core.sv =====
// IPS patch encoder top level: run tracking, run buffer RAM, byte sequencer.
// Depends on ipe_pkg, ipe_in_if, ipe_out_if, ipe_ram, ipe_out_reg and the assert header.
//
// Usage:
//   diff_items carries one base/modified byte pair per item, for every offset of the
//   modified file; base_present low means the base file has ended (always a mismatch),
//   end_of_file marks the final pair. patch_stream carries the IPS file one byte per
//   item: "PATCH" on the first item of a patch, one record (3-byte offset, 2-byte
//   length, data) per closed run, and "EOF" after the end-marked item. last_of_burst
//   flags the final byte caused by an input item, patch_done the last "EOF" byte.
//   Items are taken one at a time. An item that produces no byte is taken and the
//   next can follow at once. Otherwise the sequencer emits one byte per cycle, while
//   patch_stream does not stall, after the accept cycle, for N output bytes (N up to
//   5 + 5 + MAX_RUN + 3). Run data is replayed from the buffer RAM, whose read is
//   prefetched one byte ahead, so the RAM read does not hold up the byte stream.
//   A byte reaches patch_stream in the cycle after the sequencer produces it.
//   A stall on patch_stream freezes the sequencer; no byte is dropped, and no new
//   input item is taken until the current one has all its bytes queued.
//   Reset clears position, run state and the header flag; the buffer RAM needs no
//   clearing, since only entries written in the open run are ever read back.
`default_nettype none

module ips_patch_encoder_core #(
    parameter int MAX_RUN = 48
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ipe_in_if.sink    diff_items,
    ipe_out_if.source patch_stream
);

    import ipe_pkg::*;

    // Persistent run tracking
    logic [POS_W-1:0] position_reg;
    logic             header_sent_reg;
    logic             in_run_reg;
    logic [POS_W-1:0] run_start_reg;
    logic [RUN_W-1:0] run_length_reg;

    // Work captured for the item being emitted
    logic             job_hdr_reg;
    logic             job_rec_reg;
    logic             job_eof_reg;
    logic [POS_W-1:0] rec_start_reg;
    logic [RUN_W-1:0] rec_len_reg;

    seq_state_t       state_reg, state_next;
    logic [RUN_W-1:0] cnt_reg, cnt_next;

    // Accept-time decode
    logic             in_fire;
    logic             mismatch;
    logic             new_run;
    logic [RUN_W-1:0] wr_idx;
    logic [RUN_W-1:0] len_after;
    logic             close_now;
    logic             in_run_after;
    logic             close_at_end;
    logic             rec_any;
    logic [POS_W-1:0] start_after;

    // Sequencer outputs
    logic             push;
    logic             can_push;
    out_beat_t        beat;
    logic             ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    assign diff_items.ready = (state_reg == S_IDLE);
    assign in_fire = diff_items.valid && diff_items.ready;

    assign mismatch = !diff_items.base_present || (diff_items.base_byte != diff_items.new_byte);
    assign new_run = mismatch && !in_run_reg;
    assign wr_idx = in_run_reg ? run_length_reg : '0;
    assign len_after = mismatch ? wr_idx + RUN_W'(1) : run_length_reg;
    // Close on a match ending a run, or when the run fills.
    assign close_now = mismatch ? (len_after >= RUN_W'(MAX_RUN)) : in_run_reg;
    assign in_run_after = mismatch && !close_now;
    assign close_at_end = diff_items.end_of_file && in_run_after;
    assign rec_any = close_now || close_at_end;
    assign start_after = new_run ? position_reg : run_start_reg;

    ipe_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_run_buf (
        .clk   (clk),
        .we    (in_fire && mismatch),
        .waddr (wr_idx[ADDR_W-1:0]),
        .wdata (diff_items.new_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            header_sent_reg <= 1'b0;
            in_run_reg      <= 1'b0;
            run_start_reg   <= '0;
            run_length_reg  <= '0;
            job_hdr_reg     <= 1'b0;
            job_rec_reg     <= 1'b0;
            job_eof_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            job_hdr_reg <= !header_sent_reg;
            job_rec_reg <= rec_any;
            job_eof_reg <= diff_items.end_of_file;
            if (diff_items.end_of_file)
            begin
                // End of patch: run tracking back to reset values.
                position_reg    <= '0;
                header_sent_reg <= 1'b0;
                in_run_reg      <= 1'b0;
                run_start_reg   <= '0;
                run_length_reg  <= '0;
            end
            else
            begin
                position_reg    <= position_reg + POS_W'(1);
                header_sent_reg <= 1'b1;
                in_run_reg      <= in_run_after;
                run_start_reg   <= start_after;
                run_length_reg  <= in_run_after ? len_after : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rec_start_reg <= start_after;
            rec_len_reg   <= len_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Byte sequencer: header, record, run data, trailer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        push       = 1'b0;
        beat       = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_fire)
                begin
                    if (!header_sent_reg)
                    begin
                        state_next = S_HDR;
                    end
                    else if (rec_any)
                    begin
                        state_next = S_REC;
                    end
                    else if (diff_items.end_of_file)
                    begin
                        state_next = S_EOF;
                    end
                end
            end
            S_HDR:
            begin
                beat.out_byte      = hdr_byte(cnt_reg[2:0]);
                beat.last_of_burst = (cnt_reg == HDR_LAST_IDX) && !job_rec_reg && !job_eof_reg;
                push = can_push;
                if (push)
                begin
                    if (cnt_reg == HDR_LAST_IDX)
                    begin
                        cnt_next = '0;
                        if (job_rec_reg)
                        begin
                            state_next = S_REC;
                        end
                        else if (job_eof_reg)
                        begin
                            state_next = S_EOF;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + RUN_W'(1);
                    end
                end
            end
            S_REC:
            begin
                case (cnt_reg[2:0])
                    3'd0:    beat.out_byte = rec_start_reg[23:16];
                    3'd1:    beat.out_byte = rec_start_reg[15:8];
                    3'd2:    beat.out_byte = rec_start_reg[7:0];
                    3'd3:    beat.out_byte = 8'h00;
                    default: beat.out_byte = {{(8-RUN_W){1'b0}}, rec_len_reg};
                endcase
                push = can_push;
                if (push)
                begin
                    if (cnt_reg == REC_LAST_IDX)
                    begin
                        // Prefetch the first data byte.
                        ram_re     = 1'b1;
                        cnt_next   = '0;
                        state_next = S_DATA;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + RUN_W'(1);
                    end
                end
            end
            S_DATA:
            begin
                beat.out_byte      = ram_rdata;
                beat.last_of_burst = (cnt_reg == rec_len_reg - RUN_W'(1)) && !job_eof_reg;
                push = can_push;
                if (push)
                begin
                    if (cnt_reg == rec_len_reg - RUN_W'(1))
                    begin
                        cnt_next   = '0;
                        state_next = job_eof_reg ? S_EOF : S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = cnt_reg[ADDR_W-1:0] + ADDR_W'(1);
                        cnt_next  = cnt_reg + RUN_W'(1);
                    end
                end
            end
            S_EOF:
            begin
                beat.out_byte      = eof_byte(cnt_reg[1:0]);
                beat.last_of_burst = (cnt_reg == EOF_LAST_IDX);
                beat.patch_done    = (cnt_reg == EOF_LAST_IDX);
                push = can_push;
                if (push)
                begin
                    if (cnt_reg == EOF_LAST_IDX)
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + RUN_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    ipe_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .beat     (beat),
        .can_push (can_push),
        .tx       (patch_stream)
    );

`include "ips_patch_encoder_core_assert.svh"

    // An open run never sits at or beyond the split length between items.
    `IPE_ASSERT(a_run_below_max, run_length_reg < RUN_W'(MAX_RUN))
    // No buffered bytes without an open run.
    `IPE_ASSERT(a_len_needs_run, !in_run_reg |-> (run_length_reg == '0))
    // A fresh patch starts from offset zero with no run.
    `IPE_ASSERT(a_fresh_patch, !header_sent_reg |-> ((position_reg == '0) && !in_run_reg))
    // Data replay stays inside the captured run.
    `IPE_ASSERT(a_data_in_range, (state_reg == S_DATA) |-> (cnt_reg < rec_len_reg))
    // The trailer's final byte always closes its item's burst.
    `IPE_NEVER(a_done_is_last, push && beat.patch_done && !beat.last_of_burst)

endmodule

`default_nettype wire
